@@ rtl/stb_pkg.sv @@
// Shared types and constants for the software timer bank.
package stb_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int VAL_W = 16;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_CONFIG  = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // Per-timer counters kept in the entry memory.
    typedef struct packed {
        logic [VAL_W-1:0] delay;
        logic [VAL_W-1:0] count;
        logic [VAL_W-1:0] reload;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        entry_t nxt;
        logic   fire;
    } step_t;

endpackage

@@ rtl/stb_entry_ram.sv @@
// Entry memory: one write port, one read port with registered read data.
module stb_entry_ram
    import stb_pkg::*;
#(
    parameter int DEPTH  = NUM_TIMERS_DEF,
    parameter int ADDR_W = 3
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/stb_step_unit.sv @@
// Shared step unit: one decrement and zero test applied to the visited timer.
module stb_step_unit
    import stb_pkg::*;
(
    input  entry_t cur,
    output step_t  res
);

    logic             delay_nz;
    logic             count_nz;
    logic [VAL_W-1:0] operand;
    logic [VAL_W-1:0] dec;

    assign delay_nz = (cur.delay != '0);
    assign count_nz = (cur.count != '0);
    // one decrementer serves both the start delay and the count
    assign operand  = delay_nz ? cur.delay : cur.count;
    assign dec      = operand - VAL_W'(1);

    always_comb
    begin
        res.nxt  = cur;
        res.fire = 1'b0;
        if (delay_nz)
        begin
            res.nxt.delay = dec;
        end
        else if (count_nz)
        begin
            res.nxt.count = dec;
        end
        else
        begin
            res.nxt.count = cur.reload;
            res.fire      = 1'b1;
        end
    end

endmodule

@@ rtl/software_timer_bank_unit.sv @@
// Software timer bank: sequencer, timer flags, entry memory and result register.
// Configure and release beats keep the block idle, ready again the next cycle.
// A tick scans one timer per cycle through the shared step unit, then walks the fire
// mask one index per cycle, waiting on out_stall, one result beat per fired timer.
// The scan rate is set by the single read port of the entry memory.
// Reset clears all timer flags and the sequencer; the entry memory is not cleared.
module software_timer_bank_unit
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [2:0]        timer_index,
    input  logic              mode,
    input  logic [VAL_W-1:0]  period,
    input  logic [VAL_W-1:0]  start_delay,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        fired_timer,
    output logic              stopped,
    output logic              last
);

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
    localparam int WIDE_W = ((IDX_W > 3) ? IDX_W : 3) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [NUM_TIMERS-1:0] active_reg, active_next;
    logic [NUM_TIMERS-1:0] single_reg, single_next;
    logic [NUM_TIMERS-1:0] fired_reg, fired_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [NUM_TIMERS-1:0] fire_mask_reg, fire_mask_next;
    logic [NUM_TIMERS-1:0] stop_mask_reg, stop_mask_next;
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic                  ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]      ev_idx_reg, ev_idx_next;
    logic [IDX_W-1:0]      emit_idx_reg, emit_idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            out_timer_reg, out_timer_next;
    logic                  out_stop_reg, out_stop_next;
    logic                  out_last_reg, out_last_next;

    logic                  in_beat;
    logic [WIDE_W-1:0]     idx_wide;
    logic                  idx_hit;
    logic [IDX_W-1:0]      cfg_addr;
    logic                  eligible;
    logic                  out_free;
    logic [NUM_TIMERS-1:0] remain;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    entry_t                ram_wdata;
    entry_t                ram_rdata;
    entry_t                cfg_entry;
    step_t                 step;

    stb_entry_ram #(
        .DEPTH  (NUM_TIMERS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (ram_rdata)
    );

    stb_step_unit u_step (
        .cur (ram_rdata),
        .res (step)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_beat   = in_valid && !in_stall;
    assign idx_wide  = WIDE_W'(timer_index);
    assign idx_hit   = (idx_wide < WIDE_W'(NUM_TIMERS));
    assign cfg_addr  = idx_wide[IDX_W-1:0];
    assign out_free  = !out_valid_reg || !out_stall;

    assign cfg_entry.delay  = start_delay;
    assign cfg_entry.count  = period;
    assign cfg_entry.reload = period;

    // single-shot timers that already fired are skipped
    assign eligible = ev_vld_reg && active_reg[ev_idx_reg]
                      && !(single_reg[ev_idx_reg] && fired_reg[ev_idx_reg]);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ev_idx_reg;
        ram_wdata = step.nxt;
        if (state_reg == ST_IDLE)
        begin
            ram_we    = in_beat && (kind == KIND_CONFIG) && idx_hit;
            ram_waddr = cfg_addr;
            ram_wdata = cfg_entry;
        end
        else if (state_reg == ST_SCAN)
        begin
            ram_we = eligible;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        single_next    = single_reg;
        fired_next     = fired_reg;
        running_next   = running_reg;
        fire_mask_next = fire_mask_reg;
        stop_mask_next = stop_mask_reg;
        rd_cnt_next    = rd_cnt_reg;
        ev_vld_next    = 1'b0;
        ev_idx_next    = ev_idx_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_timer_next = out_timer_reg;
        out_stop_next  = out_stop_reg;
        out_last_next  = out_last_reg;
        remain         = fire_mask_reg;
        remain[emit_idx_reg] = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    case (kind)
                        KIND_TICK:
                        begin
                            rd_cnt_next = '0;
                            state_next  = ST_SCAN;
                        end
                        KIND_CONFIG:
                        begin
                            if (idx_hit)
                            begin
                                single_next[cfg_addr]  = mode;
                                active_next[cfg_addr]  = 1'b1;
                                running_next[cfg_addr] = 1'b1;
                                fired_next[cfg_addr]   = 1'b0;
                            end
                        end
                        KIND_RELEASE:
                        begin
                            if (idx_hit)
                            begin
                                active_next[cfg_addr]  = 1'b0;
                                running_next[cfg_addr] = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // read of timer rd_cnt overlaps the update of timer ev_idx
                if (rd_cnt_reg < CNT_W'(NUM_TIMERS))
                begin
                    ev_vld_next = 1'b1;
                    ev_idx_next = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (eligible && step.fire)
                begin
                    fire_mask_next[ev_idx_reg] = 1'b1;
                    stop_mask_next[ev_idx_reg] = single_reg[ev_idx_reg];
                    fired_next[ev_idx_reg]     = 1'b1;
                    if (single_reg[ev_idx_reg])
                    begin
                        running_next[ev_idx_reg] = 1'b0;
                    end
                end
                if ((rd_cnt_reg == CNT_W'(NUM_TIMERS)) && !ev_vld_reg)
                begin
                    emit_idx_next = '0;
                    state_next    = (fire_mask_reg == '0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (fire_mask_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (fire_mask_reg[emit_idx_reg])
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_timer_next = 3'(emit_idx_reg);
                        out_stop_next  = stop_mask_reg[emit_idx_reg];
                        out_last_next  = (remain == '0);
                        fire_mask_next = remain;
                        emit_idx_next  = emit_idx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    emit_idx_next = emit_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            single_reg    <= '0;
            fired_reg     <= '0;
            running_reg   <= '0;
            fire_mask_reg <= '0;
            stop_mask_reg <= '0;
            rd_cnt_reg    <= '0;
            ev_vld_reg    <= 1'b0;
            ev_idx_reg    <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            single_reg    <= single_next;
            fired_reg     <= fired_next;
            running_reg   <= running_next;
            fire_mask_reg <= fire_mask_next;
            stop_mask_reg <= stop_mask_next;
            rd_cnt_reg    <= rd_cnt_next;
            ev_vld_reg    <= ev_vld_next;
            ev_idx_reg    <= ev_idx_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_timer_reg <= out_timer_next;
        out_stop_reg  <= out_stop_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign fired_timer = out_timer_reg;
    assign stopped     = out_stop_reg;
    assign last        = out_last_reg;

    // pending fires exist only between scan and the end of the walk
    a_mask_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (fire_mask_reg == '0))
        else $error("fire mask not empty in idle");

    // the fire mask only gains bits during a scan
    a_mask_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |=> ((fire_mask_reg & ~$past(fire_mask_reg)) == '0))
        else $error("fire mask gained a bit outside scan");

    // the evaluate stage runs only inside a scan
    a_eval_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ev_vld_reg |-> (state_reg == ST_SCAN))
        else $error("evaluate stage active outside scan");

    // memory writes stay inside the bank
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((CNT_W + 1)'(ram_waddr) < (CNT_W + 1)'(NUM_TIMERS)))
        else $error("entry write beyond the bank");

    // a last beat empties the fire mask
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !(out_valid_reg && out_stall) && out_last_next)
        |=> (fire_mask_reg == '0))
        else $error("last beat left pending fires");

endmodule
